@@ rtl/acrms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_pkg
// Shared constants, widths and controller/datapath interface types for the
// AC RMS envelope block.
// ----------------------------------------------------------------------------
package acrms_pkg;

    localparam int MAX_BLOCK = 256;
    localparam int WINDOW    = 5;
    localparam int FRAC_BITS = 4;

    localparam int SMP_W     = 16;
    localparam int RMS_W     = 20;
    localparam int FILL_OUT_W = 3;
    localparam int OUT_TDATA_W = 48;

    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = SMP_W + $clog2(MAX_BLOCK);
    localparam int SQS_W   = 2 * SMP_W - 1 + $clog2(MAX_BLOCK);
    localparam int ABS2_W  = 2 * SUM_W;
    localparam int PROD_W  = CNT_W + SQS_W;
    localparam int DVD_W   = PROD_W + 2 * FRAC_BITS;
    localparam int DVS_W   = 2 * CNT_W;
    localparam int RAD_W   = 2 * RMS_W;
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int TOT_W   = RMS_W - 1 + $clog2(WINDOW + 1);

    typedef enum logic {
        DIV_VAR,
        DIV_AVG
    } t_div_src;

    typedef struct packed {
        logic     load;
        logic     accum;
        logic     mul_init;
        logic     mul_step;
        logic     div_start;
        t_div_src div_sel;
        logic     sqrt_start;
        logic     ring_upd;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic mul_done;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } t_status;

endpackage

@@ rtl/acrms_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acrms_div
    import acrms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int DCNT_W = $clog2(DVD_W + 1);

    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    n_shift;
    logic [DVS_W:0]    n_diff;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[DVD_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DVD_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_rem <= n_ge ? n_diff[DVS_W-1:0] : n_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], n_ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

@@ rtl/acrms_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module acrms_sqrt
    import acrms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_busy,
    output logic [RMS_W-1:0] o_root
);

    localparam int SCNT_W = $clog2(RMS_W + 1);

    logic [SCNT_W-1:0] r_cnt;
    logic [RAD_W-1:0]  r_x;
    logic [RMS_W-1:0]  r_root;
    logic [RMS_W:0]    r_rem;
    logic [RMS_W+2:0]  n_trem;
    logic [RMS_W+2:0]  n_trial;
    logic [RMS_W+2:0]  n_diff;
    logic              n_ge;

    always_comb begin
        n_trem  = {r_rem, r_x[RAD_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_diff  = n_trem - n_trial;
        n_ge    = (n_trem >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= SCNT_W'(RMS_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - SCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (o_busy) begin
            r_x    <= {r_x[RAD_W-3:0], 2'b00};
            r_root <= {r_root[RMS_W-2:0], n_ge};
            r_rem  <= n_ge ? n_diff[RMS_W:0] : n_trem[RMS_W:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

@@ rtl/acrms_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_dp
// Datapath: block accumulators, shift-add product, shared divider, square
// root, smoothing ring and output register.
// ----------------------------------------------------------------------------
module acrms_dp
    import acrms_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_last,
    input  logic                    i_restart,
    input  logic                    i_m_tready,
    output logic                    o_valid,
    output logic [RMS_W-1:0]        o_rms,
    output logic [RMS_W-1:0]        o_smooth,
    output logic [FILL_OUT_W-1:0]   o_fill
);

    logic signed [SMP_W-1:0]   r_smp;
    logic                      r_last;
    logic                      r_restart;
    logic signed [SUM_W-1:0]   r_sum;
    logic [SQS_W-1:0]          r_sumsq;
    logic [CNT_W-1:0]          r_count;
    logic [PROD_W-1:0]         r_mcand;
    logic [CNT_W-1:0]          r_mplier;
    logic [PROD_W-1:0]         r_prod;
    logic [ABS2_W-1:0]         r_absq;
    logic [DVS_W-1:0]          r_nn;
    logic [RMS_W-1:0]          r_ring [WINDOW];
    logic [POS_W-1:0]          r_pos;
    logic [FILL_W-1:0]         r_fill;
    logic [TOT_W-1:0]          r_total;
    logic [RMS_W-1:0]          r_rms;
    logic                      r_out_valid;
    logic [RMS_W-1:0]          r_out_rms;
    logic [RMS_W-1:0]          r_out_smooth;
    logic [FILL_OUT_W-1:0]     r_out_fill;

    logic signed [2*SMP_W-1:0] n_sq;
    logic [CNT_W-1:0]          n_count_inc;
    logic signed [SUM_W-1:0]   n_sum_neg;
    logic [SUM_W-1:0]          n_abs;
    logic                      n_full;
    logic [RMS_W-1:0]          n_old;
    logic [DVD_W-1:0]          n_dividend;
    logic [DVS_W-1:0]          n_divisor;
    logic                      n_div_busy;
    logic [DVD_W-1:0]          n_quo;
    logic                      n_sqrt_busy;
    logic [RMS_W-1:0]          n_root;

    always_comb begin
        n_sq        = r_smp * r_smp;
        n_count_inc = r_count + CNT_W'(1);
        n_sum_neg   = -r_sum;
        n_abs       = r_sum[SUM_W-1] ? unsigned'(n_sum_neg) : unsigned'(r_sum);
        n_full      = (r_fill >= FILL_W'(WINDOW));
        n_old       = n_full ? r_ring[r_pos] : '0;
        if (i_cmd.div_sel == DIV_VAR) begin
            n_dividend = DVD_W'(r_prod - PROD_W'(r_absq)) << (2 * FRAC_BITS);
            n_divisor  = r_nn;
        end else begin
            n_dividend = DVD_W'(r_total);
            n_divisor  = DVS_W'(r_fill);
        end
    end

    acrms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_busy     (n_div_busy),
        .o_quotient (n_quo)
    );

    acrms_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (n_quo[RAD_W-1:0]),
        .o_busy     (n_sqrt_busy),
        .o_root     (n_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_sum   <= r_sum + SUM_W'(r_smp);
                r_sumsq <= r_sumsq + SQS_W'(unsigned'(n_sq));
                r_count <= n_count_inc;
                if (r_restart) begin
                    r_pos   <= '0;
                    r_fill  <= '0;
                    r_total <= '0;
                end
            end
            if (i_cmd.mul_init) begin
                r_sum   <= '0;
                r_sumsq <= '0;
                r_count <= '0;
            end
            if (i_cmd.ring_upd) begin
                r_total <= r_total - TOT_W'(n_old) + TOT_W'(n_root);
                r_fill  <= n_full ? r_fill : r_fill + FILL_W'(1);
                r_pos   <= (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + POS_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp     <= i_sample;
            r_last    <= i_last;
            r_restart <= i_restart;
        end
        if (i_cmd.mul_init) begin
            r_absq   <= ABS2_W'(n_abs) * ABS2_W'(n_abs);
            r_nn     <= DVS_W'(r_count) * DVS_W'(r_count);
            r_mcand  <= PROD_W'(r_sumsq);
            r_mplier <= r_count;
            r_prod   <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.ring_upd) begin
            r_ring[r_pos] <= n_root;
            r_rms         <= n_root;
        end
        if (i_cmd.out_load) begin
            r_out_rms    <= r_rms;
            r_out_smooth <= n_quo[RMS_W-1:0];
            r_out_fill   <= FILL_OUT_W'(r_fill);
        end
    end

    always_comb begin
        o_status.close     = r_last || (n_count_inc == CNT_W'(MAX_BLOCK));
        o_status.mul_done  = (r_mplier == '0);
        o_status.div_busy  = n_div_busy;
        o_status.sqrt_busy = n_sqrt_busy;
        o_status.out_free  = !r_out_valid || i_m_tready;
    end

    assign o_valid  = r_out_valid;
    assign o_rms    = r_out_rms;
    assign o_smooth = r_out_smooth;
    assign o_fill   = r_out_fill;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("ring fill above window");

    a_ring_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ring_upd |=> (r_fill != '0) && (r_total >= TOT_W'(r_rms)))
        else $error("ring total or fill inconsistent after update");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output register overwritten while held");
`endif

endmodule

@@ rtl/acrms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrms_ctrl
// Sequencer: accept, accumulate, and at block end run product, divide,
// square root, ring update, average divide and output load.
// ----------------------------------------------------------------------------
module acrms_ctrl
    import acrms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MUL_INIT,
        S_MUL,
        S_DIV_VAR,
        S_SQRT,
        S_RING,
        S_AVG_START,
        S_DIV_AVG,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_VAR;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.close ? S_MUL_INIT : S_IDLE;
            end
            S_MUL_INIT: begin
                o_cmd.mul_init = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_VAR;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV_VAR: begin
                if (!i_status.div_busy) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!i_status.sqrt_busy) begin
                    n_state = S_RING;
                end
            end
            S_RING: begin
                o_cmd.ring_upd = 1'b1;
                n_state        = S_AVG_START;
            end
            S_AVG_START: begin
                o_cmd.div_sel   = DIV_AVG;
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                o_cmd.div_sel = DIV_AVG;
                if (!i_status.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.div_sel = DIV_AVG;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

@@ rtl/block_ac_rms_envelope.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_ac_rms_envelope
// AC RMS per sample block with a moving-average envelope over recent blocks.
//
// channel   dir  tdata (low bit up)                       tlast          tuser
// s_*       in   sample[15:0]                             last_of_block  restart_envelope
// m_*       out  rms_ac[19:0] smoothed[39:20] fill[42:40]  -              -
//
// A sample that does not close a block is accepted and then accumulated.
// A closing sample also runs up to 9 shift-add product steps, the 20-step
// root and two passes through the 56-step shared restoring divider.
// Reset is synchronous, active low; no clearing pass is needed.
// A finished result waits in the output register while further samples are
// accepted; only the next block end waits for it to be taken.
// ----------------------------------------------------------------------------
module block_ac_rms_envelope
    import acrms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [SMP_W-1:0]       i_s_tdata,   // [15:0] sample
    input  logic                   i_s_tlast,
    input  logic                   i_s_tuser,   // [0] restart_envelope
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [19:0] rms_ac, [39:20] smoothed,
                                                // [42:40] window_fill
);

    t_cmd                  w_cmd;
    t_status               w_status;
    logic [RMS_W-1:0]      w_rms;
    logic [RMS_W-1:0]      w_smooth;
    logic [FILL_OUT_W-1:0] w_fill;

    acrms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    acrms_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_sample   (signed'(i_s_tdata)),
        .i_last     (i_s_tlast),
        .i_restart  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_rms      (w_rms),
        .o_smooth   (w_smooth),
        .o_fill     (w_fill)
    );

    assign o_m_tdata = {(OUT_TDATA_W - 2 * RMS_W - FILL_OUT_W)'(0), w_fill, w_smooth, w_rms};

endmodule
